[design/rcfv_pkg.sv]
package rcfv_pkg;

   localparam int DEF_COORD_BITS = 12;

   // register indexes on the csr port
   localparam logic [1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   typedef enum logic [2:0] {
      MODE_ORIGINAL = 3'd0,
      MODE_MONO     = 3'd1,
      MODE_SEPIA    = 3'd2,
      MODE_WARM     = 3'd3,
      MODE_COOL     = 3'd4,
      MODE_FADED    = 3'd5
   } rcfv_mode_type;

   // unclamped channels; sepia, warm, cool and faded can exceed 255
   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } rcfv_chan3_type;

   localparam logic [15:0] LUMA_R = 16'd77;
   localparam logic [15:0] LUMA_G = 16'd150;
   localparam logic [15:0] LUMA_B = 16'd29;

   localparam logic [16:0] SEPIA_RR = 17'd101;
   localparam logic [16:0] SEPIA_RG = 17'd197;
   localparam logic [16:0] SEPIA_RB = 17'd48;
   localparam logic [16:0] SEPIA_GR = 17'd89;
   localparam logic [16:0] SEPIA_GG = 17'd176;
   localparam logic [16:0] SEPIA_GB = 17'd43;
   localparam logic [16:0] SEPIA_BR = 17'd70;
   localparam logic [16:0] SEPIA_BG = 17'd137;
   localparam logic [16:0] SEPIA_BB = 17'd34;

   localparam logic [8:0] FADE_OFS_R = 9'd18;
   localparam logic [8:0] FADE_OFS_G = 9'd12;
   localparam logic [8:0] FADE_OFS_B = 9'd4;

   // scaled reciprocals, exact over the numerator ranges used here
   localparam logic [24:0] RECIP10  = 25'd6554;   // 2^16 / 10, rounded up
   localparam logic [30:0] RECIP100 = 31'd41944;  // 2^22 / 100, rounded up
   localparam logic [24:0] RECIP6   = 25'd10923;  // 2^16 / 6, rounded up

   localparam logic [8:0] DIST_MAX  = 9'd257;
   localparam logic [9:0] EDGE_MAX  = 10'd256;
   localparam logic [8:0] SCALE_ONE = 9'd256;
   localparam logic [12:0] EDGE_GAIN = 13'd15;

   // n / 10 for n below 2856
   function automatic logic [8:0] div10(input logic [11:0] n);
      logic [24:0] p;
      p = {13'd0, n} * RECIP10;
      return p[24:16];
   endfunction

   // n / 100 for n below 26316
   function automatic logic [8:0] div100(input logic [14:0] n);
      logic [30:0] p;
      p = {16'd0, n} * RECIP100;
      return p[30:22];
   endfunction

   // n / 6 for n below 1534
   function automatic logic [7:0] div6(input logic [10:0] n);
      logic [24:0] p;
      p = {14'd0, n} * RECIP6;
      return p[23:16];
   endfunction

endpackage

[design/rgb_color_filter_vignette_core.sv]
// Per-pixel color filter with radial vignette for a streamed camera image.
//
// Input: one item per pixel: req_color_in (R 23:16, G 15:8, B 7:0) plus its
// column/row in req_pos_x/req_pos_y. An item is taken at a rising edge with
// start high and busy low. busy is always low: the block is a free-running
// pipeline and takes one item every cycle, back to back.
// Output: rsp_valid strobes for exactly one cycle with rsp_red_out,
// rsp_green_out and rsp_blue_out. Results leave in input order through 8
// register stages, set by the 9-step axis divider plus the
// square/scale/multiply stages. The receiver cannot stall; it must take
// each result in its strobe cycle.
// Config: csr_wen/csr_index/csr_wdata write filter mode, frame width and
// frame height. Write only while no items are in flight.
// Reset (synchronous, active high) clears the valid chain and the registers
// (mode original, vignette off). Items in flight at reset are dropped.
module rgb_color_filter_vignette_core #(
   parameter int COORD_BITS = rcfv_pkg::DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  start,
   output logic                  busy,
   input  logic [23:0]           req_color_in,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   // result output
   output logic                  rsp_valid,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   // config writes
   input  logic                  csr_wen,
   input  logic [1:0]            csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);
   import rcfv_pkg::*;

   localparam int STAGES = 8;
   localparam int DLY    = 4;  // color result (stage 2) waits for scale (stage 6)

   // ---------------- config registers ----------------
   logic [2:0]            filter_mode_ff, filter_mode_in;
   logic [COORD_BITS-1:0] frame_width_ff, frame_width_in;
   logic [COORD_BITS-1:0] frame_height_ff, frame_height_in;

   always_comb begin
      filter_mode_in  = filter_mode_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_FILTER_MODE:  filter_mode_in  = csr_wdata[2:0];
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= '0;
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else begin
         filter_mode_ff  <= filter_mode_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // ---------------- handshake and valid chain ----------------
   logic                accept;
   logic [STAGES-1:0]   vld_ff, vld_in;

   assign busy   = 1'b0;       // pipeline never backs up
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 0: input capture ----------------
   logic [23:0]           color_ff;
   logic [COORD_BITS-1:0] pos_x_ff, pos_y_ff;

   always_ff @(posedge clock) begin
      color_ff <= req_color_in;
      pos_x_ff <= req_pos_x;
      pos_y_ff <= req_pos_y;
   end

   // ---------------- color path: stages 1-2 ----------------
   rcfv_chan3_type chan_s2;

   rcfv_color u_color (
      .clock   (clock),
      .color_i (color_ff),
      .mode_i  (filter_mode_ff),
      .chan_o  (chan_s2)
   );

   // hold the color result until the vignette scale is ready
   rcfv_chan3_type chan_dly_ff [0:DLY-1];
   rcfv_chan3_type chan_dly_in [0:DLY-1];

   always_comb begin
      chan_dly_in[0] = chan_s2;
      for (int i = 1; i < DLY; i++) begin
         chan_dly_in[i] = chan_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      chan_dly_ff <= chan_dly_in;
   end

   // ---------------- vignette path: stages 1-6 ----------------
   // per-axis normalized distance (stages 1-4), squares and scale (5-6)
   logic [8:0] dist_x, dist_y;
   logic [8:0] scale_s6;

   rcfv_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock  (clock),
      .pos_i  (pos_x_ff),
      .size_i (frame_width_ff),
      .dist_o (dist_x)
   );

   rcfv_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock  (clock),
      .pos_i  (pos_y_ff),
      .size_i (frame_height_ff),
      .dist_o (dist_y)
   );

   rcfv_shade u_shade (
      .clock    (clock),
      .dist_x_i (dist_x),
      .dist_y_i (dist_y),
      .scale_o  (scale_s6)
   );

   // ---------------- stage 7: scale, clamp, output ----------------
   logic vig_en;
   rcfv_chan3_type chan_s6;
   logic [7:0] red_ff, green_ff, blue_ff, red_in, green_in, blue_in;

   // vignette only in faded mode with a nonzero frame size
   assign vig_en  = (filter_mode_ff == MODE_FADED) &&
                    (frame_width_ff != '0) && (frame_height_ff != '0);
   assign chan_s6 = chan_dly_ff[DLY-1];

   function automatic logic [7:0] shade_clamp(input logic [8:0] c,
                                              input logic [8:0] scale,
                                              input logic       en);
      logic [17:0] p;
      logic [9:0]  v;
      p = {9'd0, c} * {9'd0, scale};
      v = en ? p[17:8] : {1'b0, c};
      return (v > 10'd255) ? 8'd255 : v[7:0];
   endfunction

   assign red_in   = shade_clamp(chan_s6.red,   scale_s6, vig_en);
   assign green_in = shade_clamp(chan_s6.green, scale_s6, vig_en);
   assign blue_in  = shade_clamp(chan_s6.blue,  scale_s6, vig_en);

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid     = vld_ff[STAGES-1];
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

endmodule

[design/rcfv_axis.sv]
module rcfv_axis #(
   parameter int COORD_BITS = rcfv_pkg::DEF_COORD_BITS
) (
   input  logic                  clock,
   input  logic [COORD_BITS-1:0] pos_i,
   input  logic [COORD_BITS-1:0] size_i,
   output logic [8:0]            dist_o
);
   import rcfv_pkg::*;

   localparam int CW = COORD_BITS;

   // distance from center scaled by 256/half, long division 3 bits a stage
   logic [CW-1:0] half;
   logic [CW-1:0] den;
   logic [CW-1:0] diff;
   logic          sat;

   logic [CW-1:0] rem_ff [0:3];
   logic [CW-1:0] rem_in [0:3];
   logic [8:0]    quo_ff [0:3];
   logic [8:0]    quo_in [0:3];
   logic [CW-1:0] den_ff [0:3];
   logic [CW-1:0] den_in [0:3];
   logic          sat_ff [0:3];
   logic          sat_in [0:3];

   assign half = {1'b0, size_i[CW-1:1]};
   assign den  = (half == '0) ? CW'(1) : half;
   assign diff = (pos_i >= half) ? (pos_i - half) : (half - pos_i);
   // quotient of 512 or more: saturates anyway
   assign sat  = {1'b0, diff} >= {den, 1'b0};

   always_comb begin
      logic [CW-1:0] r;
      logic [8:0]    q;
      rem_in[0] = diff;
      quo_in[0] = '0;
      den_in[0] = den;
      sat_in[0] = sat;
      for (int s = 0; s < 3; s++) begin
         r = rem_ff[s];
         q = quo_ff[s];
         for (int j = 0; j < 3; j++) begin
            if (s != 0 || j != 0) begin
               r = {r[CW-2:0], 1'b0};
            end
            if (r >= den_ff[s]) begin
               r = r - den_ff[s];
               q = {q[7:0], 1'b1};
            end else begin
               q = {q[7:0], 1'b0};
            end
         end
         rem_in[s+1] = r;
         quo_in[s+1] = q;
         den_in[s+1] = den_ff[s];
         sat_in[s+1] = sat_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
   end

   assign dist_o = (sat_ff[3] || quo_ff[3] > DIST_MAX) ? DIST_MAX : quo_ff[3];

endmodule

[design/rcfv_color.sv]
module rcfv_color (
   input  logic                     clock,
   input  logic [23:0]              color_i,
   input  logic [2:0]               mode_i,
   output rcfv_pkg::rcfv_chan3_type chan_o
);
   import rcfv_pkg::*;

   logic [7:0] r, g, b;
   logic [15:0] luma_sum;
   logic [16:0] sep_r_sum, sep_g_sum, sep_b_sum;

   logic [7:0]  r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic [7:0]  luma_ff, luma_in;
   logic [8:0]  sep_r_ff, sep_g_ff, sep_b_ff, sep_r_in, sep_g_in, sep_b_in;
   logic [11:0] warm_r_ff, warm_b_ff, cool_b_ff, warm_r_in, warm_b_in, cool_b_in;
   logic [14:0] warm_g_ff, cool_r_ff, cool_g_ff, warm_g_in, cool_r_in, cool_g_in;

   rcfv_chan3_type chan_ff, chan_in;

   assign r = color_i[23:16];
   assign g = color_i[15:8];
   assign b = color_i[7:0];

   assign luma_sum  = 16'(r) * LUMA_R + 16'(g) * LUMA_G + 16'(b) * LUMA_B;
   assign sep_r_sum = 17'(r) * SEPIA_RR + 17'(g) * SEPIA_RG + 17'(b) * SEPIA_RB;
   assign sep_g_sum = 17'(r) * SEPIA_GR + 17'(g) * SEPIA_GG + 17'(b) * SEPIA_GB;
   assign sep_b_sum = 17'(r) * SEPIA_BR + 17'(g) * SEPIA_BG + 17'(b) * SEPIA_BB;

   assign r_in = r;
   assign g_in = g;
   assign b_in = b;
   assign luma_in  = luma_sum[15:8];
   assign sep_r_in = sep_r_sum[16:8];
   assign sep_g_in = sep_g_sum[16:8];
   assign sep_b_in = sep_b_sum[16:8];

   // rounding numerators for the gain modes
   assign warm_r_in = 12'(r) * 12'd11 + 12'd50;
   assign warm_g_in = 15'(g) * 15'd103 + 15'd50;
   assign warm_b_in = 12'(b) * 12'd9 + 12'd50;
   assign cool_r_in = 15'(r) * 15'd93 + 15'd50;
   assign cool_g_in = 15'(g) * 15'd101 + 15'd50;
   assign cool_b_in = 12'(b) * 12'd11 + 12'd50;

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      g_ff      <= g_in;
      b_ff      <= b_in;
      luma_ff   <= luma_in;
      sep_r_ff  <= sep_r_in;
      sep_g_ff  <= sep_g_in;
      sep_b_ff  <= sep_b_in;
      warm_r_ff <= warm_r_in;
      warm_g_ff <= warm_g_in;
      warm_b_ff <= warm_b_in;
      cool_r_ff <= cool_r_in;
      cool_g_ff <= cool_g_in;
      cool_b_ff <= cool_b_in;
   end

   always_comb begin
      logic [10:0] l2;
      l2 = {2'd0, luma_ff, 1'b0} + 11'd3;
      case (mode_i)
         MODE_MONO: begin
            chan_in.red   = {1'b0, luma_ff};
            chan_in.green = {1'b0, luma_ff};
            chan_in.blue  = {1'b0, luma_ff};
         end
         MODE_SEPIA: begin
            chan_in.red   = sep_r_ff;
            chan_in.green = sep_g_ff;
            chan_in.blue  = sep_b_ff;
         end
         MODE_WARM: begin
            chan_in.red   = div10(warm_r_ff);
            chan_in.green = div100(warm_g_ff);
            chan_in.blue  = div10(warm_b_ff);
         end
         MODE_COOL: begin
            chan_in.red   = div100(cool_r_ff);
            chan_in.green = div100(cool_g_ff);
            chan_in.blue  = div10(cool_b_ff);
         end
         MODE_FADED: begin
            chan_in.red   = {1'b0, div6({1'b0, r_ff, 2'b0} + l2)} + FADE_OFS_R;
            chan_in.green = {1'b0, div6({1'b0, g_ff, 2'b0} + l2)} + FADE_OFS_G;
            chan_in.blue  = {1'b0, div6({1'b0, b_ff, 2'b0} + l2)} + FADE_OFS_B;
         end
         default: begin
            chan_in.red   = {1'b0, r_ff};
            chan_in.green = {1'b0, g_ff};
            chan_in.blue  = {1'b0, b_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
   end

   assign chan_o = chan_ff;

endmodule

[design/rcfv_shade.sv]
module rcfv_shade (
   input  logic       clock,
   input  logic [8:0] dist_x_i,
   input  logic [8:0] dist_y_i,
   output logic [8:0] scale_o
);
   import rcfv_pkg::*;

   logic [16:0] sq_x_ff, sq_y_ff, sq_x_in, sq_y_in;
   logic [17:0] sq_sum;
   logic [9:0]  edge_raw;
   logic [9:0]  edge_sat;
   logic [12:0] edge_prod;
   logic [8:0]  scale_ff, scale_in;

   assign sq_x_in = 17'(dist_x_i) * 17'(dist_x_i);
   assign sq_y_in = 17'(dist_y_i) * 17'(dist_y_i);

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
   end

   assign sq_sum    = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign edge_raw  = sq_sum[17:8];
   assign edge_sat  = (edge_raw > EDGE_MAX) ? EDGE_MAX : edge_raw;
   assign edge_prod = {3'd0, edge_sat} * EDGE_GAIN;
   assign scale_in  = SCALE_ONE - {4'd0, edge_prod[12:8]};

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

   assign scale_o = scale_ff;

endmodule

[bench/rgb_color_filter_vignette_core_tb.sv]
module rgb_color_filter_vignette_core_tb;
   import rcfv_pkg::*;

   localparam int CB = DEF_COORD_BITS;

   // codes 6 and 7 are unused filter modes: the pixel must pass unchanged
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;
   // index 3 on the csr port maps to no register
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int SETTLE_CYCLES  = 12;   // pipeline depth plus margin
   localparam int WATCHDOG_LIMIT = 400;  // quiet cycles before giving up
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 75;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb8_type;

   typedef enum logic [1:0] {
      STEP_PIXEL,
      STEP_WRITE,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [23:0]   color;
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic [1:0]    idx;
      logic [CB-1:0] data;
      int unsigned   gap;
   } plan_step_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [23:0]   req_color_in = '0;
   logic [CB-1:0] req_pos_x = '0;
   logic [CB-1:0] req_pos_y = '0;
   logic          rsp_valid;
   logic [7:0]    rsp_red_out;
   logic [7:0]    rsp_green_out;
   logic [7:0]    rsp_blue_out;
   logic          csr_wen = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   // stimulus still to be driven, and filtered pixels still owed by the block
   plan_step_type pixel_plan[$];
   rgb8_type      owed_rgb[$];

   // shadow copy of the configuration registers
   logic [2:0]    cfg_mode;
   logic [CB-1:0] cfg_width;
   logic [CB-1:0] cfg_height;

   logic        took_item = 1'b0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mode_hits[8];
   int unsigned vignette_hits = 0;

   rgb_color_filter_vignette_core #(
      .COORD_BITS(CB)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_color_in (req_color_in),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .rsp_valid    (rsp_valid),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // normalized distance from the frame center along one axis, 256 = edge;
   // capped at 257 since anything that far already saturates the vignette
   function automatic int unsigned axis_offset(input logic [CB-1:0] pos,
                                               input logic [CB-1:0] size);
      int unsigned half, span, diff, d;
      half = size / 2;
      span = (half == 0) ? 1 : half;
      diff = (pos >= half) ? pos - half : half - pos;
      d    = (diff * 256) / span;
      return (d > 257) ? 257 : d;
   endfunction

   function automatic rgb8_type filter_pixel(input logic [2:0]    mode,
                                             input logic [CB-1:0] w,
                                             input logic [CB-1:0] h,
                                             input logic [23:0]   color,
                                             input logic [CB-1:0] x,
                                             input logic [CB-1:0] y);
      int unsigned r, g, b, luma, nr, ng, nb, dx, dy, edge_sq, scale;
      rgb8_type res;
      r    = color[23:16];
      g    = color[15:8];
      b    = color[7:0];
      luma = (77 * r + 150 * g + 29 * b) >> 8;
      nr   = r;
      ng   = g;
      nb   = b;
      case (mode)
         MODE_MONO: begin
            nr = luma;
            ng = luma;
            nb = luma;
         end
         MODE_SEPIA: begin
            nr = (101 * r + 197 * g + 48 * b) >> 8;
            ng = (89 * r + 176 * g + 43 * b) >> 8;
            nb = (70 * r + 137 * g + 34 * b) >> 8;
         end
         MODE_WARM: begin
            nr = (r * 11 + 50) / 10;
            ng = (g * 103 + 50) / 100;
            nb = (b * 9 + 50) / 10;
         end
         MODE_COOL: begin
            nr = (r * 93 + 50) / 100;
            ng = (g * 101 + 50) / 100;
            nb = (b * 11 + 50) / 10;
         end
         MODE_FADED: begin
            nr = (r * 4 + luma * 2 + 3) / 6 + 18;
            ng = (g * 4 + luma * 2 + 3) / 6 + 12;
            nb = (b * 4 + luma * 2 + 3) / 6 + 4;
            if (w != 0 && h != 0) begin
               dx      = axis_offset(x, w);
               dy      = axis_offset(y, h);
               edge_sq = (dx * dx + dy * dy) >> 8;
               if (edge_sq > 256) edge_sq = 256;
               scale = 256 - (edge_sq * 15) / 256;
               nr    = (nr * scale) >> 8;
               ng    = (ng * scale) >> 8;
               nb    = (nb * scale) >> 8;
            end
         end
         default: ;  // original and the unused codes pass through
      endcase
      res.red   = (nr > 255) ? 8'd255 : nr[7:0];
      res.green = (ng > 255) ? 8'd255 : ng[7:0];
      res.blue  = (nb > 255) ? 8'd255 : nb[7:0];
      return res;
   endfunction

   function automatic void check_channel(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Plan building
   // ------------------------------------------------------------------

   task automatic plan_pixel(input logic [23:0] color, input logic [CB-1:0] x,
                             input logic [CB-1:0] y, input int unsigned gap);
      plan_step_type s;
      s.kind  = STEP_PIXEL;
      s.color = color;
      s.x     = x;
      s.y     = y;
      s.idx   = '0;
      s.data  = '0;
      s.gap   = gap;
      pixel_plan.push_back(s);
   endtask

   // pipeline must be empty before a register changes
   task automatic plan_drain();
      plan_step_type s;
      s.kind  = STEP_DRAIN;
      s.color = '0;
      s.x     = '0;
      s.y     = '0;
      s.idx   = '0;
      s.data  = '0;
      s.gap   = 0;
      pixel_plan.push_back(s);
   endtask

   task automatic plan_write(input logic [1:0] idx, input logic [CB-1:0] data);
      plan_step_type s;
      plan_drain();
      s.kind  = STEP_WRITE;
      s.color = '0;
      s.x     = '0;
      s.y     = '0;
      s.idx   = idx;
      s.data  = data;
      s.gap   = 0;
      pixel_plan.push_back(s);
   endtask

   // mode write with junk in the bits above the 3-bit field
   task automatic plan_mode(input logic [2:0] mode);
      logic [CB-1:0] data;
      data      = CB'($urandom());
      data[2:0] = mode;
      plan_write(CSR_FILTER_MODE, data);
   endtask

   // mix of disabled, tiny, full and random frame sizes
   function automatic logic [CB-1:0] pick_frame_size();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CB'(1);
         2:       return '1;
         3:       return CB'($urandom_range(2, 64));
         default: return CB'($urandom_range(1, (1 << CB) - 1));
      endcase
   endfunction

   // mostly inside the frame so the vignette gradient gets exercised
   function automatic logic [CB-1:0] pick_pos(input logic [CB-1:0] size);
      if (size != 0 && $urandom_range(0, 4) != 0) return CB'($urandom_range(0, size));
      return CB'($urandom());
   endfunction

   function automatic logic [23:0] pick_color();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return 24'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: inputs move on the falling edge
   // ------------------------------------------------------------------
   int unsigned gap_left = 0;
   int unsigned settle_cnt = 0;

   always @(negedge clock) begin : drive
      logic          nx_start;
      logic          nx_wen;
      plan_step_type step;
      if (reset) begin
         start    <= 1'b0;
         csr_wen  <= 1'b0;
         gap_left = 0;
         settle_cnt = 0;
      end else if (start && !took_item) begin
         // item offered but not taken yet: hold it
      end else begin
         nx_start = 1'b0;
         nx_wen   = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pixel_plan.size() != 0) begin
            step = pixel_plan[0];
            case (step.kind)
               STEP_PIXEL: begin
                  nx_start = 1'b1;
                  req_color_in <= step.color;
                  req_pos_x    <= step.x;
                  req_pos_y    <= step.y;
                  gap_left = step.gap;
                  void'(pixel_plan.pop_front());
               end
               STEP_WRITE: begin
                  nx_wen = 1'b1;
                  csr_index <= step.idx;
                  csr_wdata <= step.data;
                  void'(pixel_plan.pop_front());
               end
               STEP_DRAIN: begin
                  // wait for every owed pixel, then let the settle counter run out
                  if (owed_rgb.size() != 0) begin
                     settle_cnt = 0;
                  end else if (settle_cnt >= SETTLE_CYCLES) begin
                     settle_cnt = 0;
                     void'(pixel_plan.pop_front());
                  end else begin
                     settle_cnt++;
                  end
               end
               default: ;
            endcase
         end
         start   <= nx_start;
         csr_wen <= nx_wen;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: samples on the rising edge, predicts and checks
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rgb8_type want;
      logic     active;
      if (reset) begin
         took_item  <= 1'b0;
         cfg_mode   = MODE_ORIGINAL;
         cfg_width  = '0;
         cfg_height = '0;
         quiet_cycles = 0;
      end else begin
         active = 1'b0;
         took_item <= start && !busy;

         // results leave in order; check against the oldest owed pixel
         if (rsp_valid) begin
            active = 1'b1;
            if (owed_rgb.size() == 0) begin
               $error("result with no pixel outstanding: r=%0d g=%0d b=%0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
               fail_count++;
            end else begin
               want = owed_rgb.pop_front();
               check_channel("red_out", want.red, rsp_red_out);
               check_channel("green_out", want.green, rsp_green_out);
               check_channel("blue_out", want.blue, rsp_blue_out);
            end
         end

         if (start && !busy) begin
            active = 1'b1;
            owed_rgb.push_back(filter_pixel(cfg_mode, cfg_width, cfg_height,
                                            req_color_in, req_pos_x, req_pos_y));
            mode_hits[cfg_mode]++;
            if (cfg_mode == MODE_FADED && cfg_width != 0 && cfg_height != 0)
               vignette_hits++;
         end

         // bits above each register's width are dropped; index 3 is a no-op
         if (csr_wen) begin
            case (csr_index)
               CSR_FILTER_MODE:  cfg_mode = csr_wdata[2:0];
               CSR_FRAME_WIDTH:  cfg_width = csr_wdata;
               CSR_FRAME_HEIGHT: cfg_height = csr_wdata;
               default: ;
            endcase
         end

         quiet_cycles = active ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item or result for %0d cycles", WATCHDOG_LIMIT);
            $display("rgb_color_filter_vignette_core_tb: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus plan, reset, and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [2:0]    dir_modes[6];
      logic [2:0]    m;
      logic [CB-1:0] w;
      logic [CB-1:0] h;
      int            density;
      int unsigned   gap;

      // --- directed part ---
      // straight out of reset: original mode, vignette off
      plan_pixel(24'hFFFFFF, '1, '1, 0);

      dir_modes = '{MODE_MONO, MODE_SEPIA, MODE_WARM, MODE_COOL, MODE_SPARE6, MODE_SPARE7};
      foreach (dir_modes[i]) begin
         plan_mode(dir_modes[i]);
         plan_pixel(24'hFFFFFF, 0, 0, 0);
         plan_pixel(pick_color(), '1, 0, 0);
      end

      // faded on the largest frame: center, corners
      plan_write(CSR_FRAME_WIDTH, '1);
      plan_write(CSR_FRAME_HEIGHT, '1);
      plan_mode(MODE_FADED);
      plan_pixel(24'hFFFFFF, 2047, 2047, 0);
      plan_pixel(24'hFFFFFF, 0, 0, 0);
      plan_pixel(pick_color(), '1, '1, 0);
      plan_pixel(24'h000000, '1, 0, 0);

      // 1x1 frame: half-size falls back to 1, far positions saturate
      plan_write(CSR_FRAME_WIDTH, 1);
      plan_write(CSR_FRAME_HEIGHT, 1);
      plan_pixel(24'hFFFFFF, 0, 0, 0);
      plan_pixel(24'hFFFFFF, '1, '1, 0);

      // one zero dimension turns the vignette off
      plan_write(CSR_FRAME_WIDTH, 640);
      plan_write(CSR_FRAME_HEIGHT, 0);
      plan_pixel(24'hFFFFFF, 0, 0, 0);
      plan_write(CSR_FRAME_WIDTH, 0);
      plan_write(CSR_FRAME_HEIGHT, 480);
      plan_pixel(24'hFFFFFF, '1, 0, 0);

      // write to the unmapped index must leave everything alone
      plan_write(CSR_SPARE, CB'($urandom()));
      plan_pixel(24'h80C040, 100, 200, 0);

      // --- random phases: every mode once, then faded with varied frames ---
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         m = (ph < 8) ? ph[2:0] : MODE_FADED;
         w = pick_frame_size();
         h = pick_frame_size();
         plan_write(CSR_FRAME_WIDTH, w);
         plan_write(CSR_FRAME_HEIGHT, h);
         plan_mode(m);
         // no idling in the last phases; elsewhere none, sparse or dense gaps
         density = (ph >= PHASE_COUNT - 2) ? 0 : $urandom_range(0, 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gap = 0;
            if (density == 1 && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 18);
            if (density == 2 && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 18);
            plan_pixel(pick_color(), pick_pos(w), pick_pos(h), gap);
            // sender holds off until the pipeline has fully drained
            if (ph % 2 == 1 && ph < PHASE_COUNT - 2 && n == PHASE_ITEMS / 2)
               plan_drain();
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pixel_plan.size() != 0 || start || owed_rgb.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (owed_rgb.size() != 0) begin
         $error("%0d filtered pixels never came out", owed_rgb.size());
         fail_count++;
      end

      $display("summary: pixels per mode 0..7 = %0d %0d %0d %0d %0d %0d %0d %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
               mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
      $display("summary: %0d faded pixels went through the vignette", vignette_hits);
      if (fail_count == 0) begin
         $display("rgb_color_filter_vignette_core_tb: clean");
      end else begin
         $display("rgb_color_filter_vignette_core_tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
design/rcfv_pkg.sv
design/rcfv_axis.sv
design/rcfv_color.sv
design/rcfv_shade.sv
design/rgb_color_filter_vignette_core.sv
bench/rgb_color_filter_vignette_core_tb.sv
